// ----- sv/ifr_pkg.sv -----
// Shared types, constants and the byte classifier of the info frame receiver.
package ifr_pkg;

	// Framing bytes.
	localparam logic [7:0] FLAG_BYTE   = 8'h7E;
	localparam logic [7:0] ESC_BYTE    = 8'h7D;
	localparam logic [7:0] ESC_FLAG    = 8'h5E;
	localparam logic [7:0] ESC_ESC     = 8'h5D;
	localparam logic [7:0] ADDR_BYTE   = 8'h03;
	localparam logic [7:0] CTL_SEQ0    = 8'h00;
	localparam logic [7:0] CTL_SEQ1    = 8'h40;
	localparam logic [7:0] HCHK_SEQ0   = 8'h03;
	localparam logic [7:0] HCHK_SEQ1   = 8'h43;
	localparam logic [7:0] CTL_DISC    = 8'h0B;
	localparam logic [7:0] HCHK_DISC   = 8'h08;

	// Payload count width and its saturation limit.
	localparam int CNT_W = 13;
	localparam logic [CNT_W-1:0] MAX_FRAME_BYTES = 13'd4096;

	// Queue depths.
	localparam int CMDQ_DEPTH = 4;
	localparam int CMDQ_AW    = $clog2(CMDQ_DEPTH);
	localparam int RESQ_DEPTH = 2;
	localparam int RESQ_AW    = $clog2(RESQ_DEPTH);

	// Result event codes.
	typedef enum logic [2:0] {
		EV_DATA   = 3'd0,
		EV_ACCEPT = 3'd1,
		EV_REJECT = 3'd2,
		EV_DUP    = 3'd3,
		EV_DISC   = 3'd4
	} ev_t;

	// Byte class flags computed in the front part.
	typedef struct packed {
		logic is_flag;
		logic is_esc;
		logic is_esc_flag;
		logic is_esc_esc;
		logic is_addr;
		logic is_ctl0;
		logic is_ctl1;
		logic is_hchk1;
		logic is_ctl_disc;
		logic is_hchk_disc;
	} cls_t;

	// One classified line byte.
	typedef struct packed {
		logic [7:0] rx_byte;
		cls_t       cls;
	} cmd_t;

	// Head of the command queue as seen by the back part.
	typedef struct packed {
		logic valid;
		cmd_t cmd;
	} cmd_head_t;

	// One result item.
	typedef struct packed {
		ev_t              ev;
		logic [7:0]       data;
		logic             seq;
		logic [CNT_W-1:0] cnt;
	} res_t;

	// Compare a line byte against every constant the parser needs.
	function automatic cls_t classify(input logic [7:0] b);
		cls_t c;
		c.is_flag      = (b == FLAG_BYTE);
		c.is_esc       = (b == ESC_BYTE);
		c.is_esc_flag  = (b == ESC_FLAG);
		c.is_esc_esc   = (b == ESC_ESC);
		c.is_addr      = (b == ADDR_BYTE);
		c.is_ctl0      = (b == CTL_SEQ0);
		c.is_ctl1      = (b == CTL_SEQ1);
		c.is_hchk1     = (b == HCHK_SEQ1);
		c.is_ctl_disc  = (b == CTL_DISC);
		c.is_hchk_disc = (b == HCHK_DISC);
		return c;
	endfunction

endpackage

// ----- sv/ifr_front.sv -----
// Front part: classifies incoming line bytes and queues them for the parser.
module ifr_front import ifr_pkg::*; (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       push,
	input  logic [7:0] rx_byte,
	output logic       full,
	output cmd_head_t  head,
	input  logic       take
);

	cmd_t                mem_q [CMDQ_DEPTH];
	logic [CMDQ_AW-1:0]  wr_ptr_q;
	logic [CMDQ_AW-1:0]  rd_ptr_q;
	logic [CMDQ_AW:0]    cnt_q;
	logic                do_push;
	logic                do_take;

	assign full    = (cnt_q == (CMDQ_AW+1)'(CMDQ_DEPTH));
	assign do_push = push && !full;
	assign do_take = take && (cnt_q != '0);

	assign head.valid = (cnt_q != '0);
	assign head.cmd   = mem_q[rd_ptr_q];

	// Queue storage: each accepted transaction is stored with its class flags.
	always_ff @(posedge clk) begin
		if (do_push) begin
			mem_q[wr_ptr_q] <= '{rx_byte: rx_byte, cls: classify(rx_byte)};
		end
	end

	// Queue pointers and fill count.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			cnt_q    <= '0;
		end else begin
			if (do_push) wr_ptr_q <= wr_ptr_q + 1'b1;
			if (do_take) rd_ptr_q <= rd_ptr_q + 1'b1;
			if (do_push && !do_take) cnt_q <= cnt_q + 1'b1;
			else if (!do_push && do_take) cnt_q <= cnt_q - 1'b1;
		end
	end

endmodule

// ----- sv/ifr_back.sv -----
// Back part: frame parser state machine and the result queue.
module ifr_back import ifr_pkg::*; (
	input  logic             clk,
	input  logic             arst_n,
	input  cmd_head_t        head,
	output logic             take,
	input  logic             pop,
	output logic             empty,
	output logic [2:0]       event_res,
	output logic [7:0]       data_byte,
	output logic             ack_seq,
	output logic [CNT_W-1:0] payload_count
);

	typedef enum logic [2:0] {
		PH_HUNT, PH_FLAG, PH_ADDR, PH_HCHK, PH_DATA, PH_ESC, PH_DCHK, PH_DEND
	} phase_t;

	phase_t              phase_q;
	logic                exp_seq_q;
	logic [7:0]          check_q;
	logic [7:0]          held_q;
	logic                held_valid_q;
	logic [CNT_W-1:0]    count_q;

	res_t                resq_q [RESQ_DEPTH];
	logic [RESQ_AW-1:0]  res_wr_q;
	logic [RESQ_AW-1:0]  res_rd_q;
	logic [RESQ_AW:0]    res_cnt_q;

	// Next-state signals of the parser.
	phase_t              phase_d;
	logic                exp_seq_d;
	logic [7:0]          check_d;
	logic [7:0]          held_d;
	logic                held_valid_d;
	logic [CNT_W-1:0]    count_d;
	logic                emit;
	res_t                res;

	logic                do_pop;
	logic                res_room;
	cls_t                c;
	logic [7:0]          b;
	logic                ctl_match;
	logic                ctl_other;
	logic                hchk_match;
	logic                data_in;
	logic [7:0]          data_val;
	logic [CNT_W-1:0]    count_inc;

	assign empty    = (res_cnt_q == '0);
	assign do_pop   = pop && !empty;
	assign res_room = (res_cnt_q != (RESQ_AW+1)'(RESQ_DEPTH)) || do_pop;
	assign take     = head.valid && res_room;

	assign c = head.cmd.cls;
	assign b = head.cmd.rx_byte;

	// Header matches depend on the expected sequence bit.
	assign ctl_match  = exp_seq_q ? c.is_ctl1 : c.is_ctl0;
	assign ctl_other  = exp_seq_q ? c.is_ctl0 : c.is_ctl1;
	assign hchk_match = exp_seq_q ? c.is_hchk1 : c.is_addr;
	assign count_inc  = (count_q < MAX_FRAME_BYTES) ? count_q + 1'b1 : count_q;

	// Parser next state and the result that one byte causes.
	always_comb begin
		phase_d      = phase_q;
		exp_seq_d    = exp_seq_q;
		check_d      = check_q;
		held_d       = held_q;
		held_valid_d = held_valid_q;
		count_d      = count_q;
		emit         = 1'b0;
		res          = '{ev: EV_DATA, data: 8'h00, seq: exp_seq_q, cnt: '0};
		data_in      = 1'b0;
		data_val     = b;
		case (phase_q)
			PH_HUNT: begin
				phase_d = c.is_flag ? PH_FLAG : PH_HUNT;
			end
			PH_FLAG: begin
				if (c.is_flag) phase_d = PH_FLAG;
				else if (c.is_addr) phase_d = PH_ADDR;
				else phase_d = PH_HUNT;
			end
			PH_ADDR: begin
				if (c.is_flag) begin
					phase_d = PH_FLAG;
				end else if (ctl_match) begin
					phase_d = PH_HCHK;
				end else if (ctl_other) begin
					phase_d = PH_HUNT;
					emit    = 1'b1;
					res.ev  = EV_DUP;
				end else if (c.is_ctl_disc) begin
					phase_d = PH_DCHK;
				end else begin
					phase_d = PH_HUNT;
				end
			end
			PH_HCHK: begin
				if (c.is_flag) begin
					phase_d = PH_FLAG;
				end else if (hchk_match) begin
					phase_d      = PH_DATA;
					check_d      = 8'h00;
					held_d       = 8'h00;
					held_valid_d = 1'b0;
					count_d      = '0;
				end else begin
					phase_d = PH_HUNT;
				end
			end
			PH_DATA: begin
				if (c.is_flag) begin
					phase_d = PH_HUNT;
					emit    = 1'b1;
					res.cnt = count_q;
					if (held_q == check_q) begin
						exp_seq_d = !exp_seq_q;
						res.ev    = EV_ACCEPT;
						res.seq   = !exp_seq_q;
					end else begin
						res.ev = EV_REJECT;
					end
				end else if (c.is_esc) begin
					phase_d = PH_ESC;
				end else begin
					data_in = 1'b1;
				end
			end
			PH_ESC: begin
				if (c.is_esc_esc) begin
					data_in  = 1'b1;
					data_val = ESC_BYTE;
				end else if (c.is_esc_flag) begin
					data_in  = 1'b1;
					data_val = FLAG_BYTE;
				end else begin
					phase_d = PH_HUNT;
					emit    = 1'b1;
					res.ev  = EV_REJECT;
					res.cnt = count_q;
				end
			end
			PH_DCHK: begin
				if (c.is_flag) phase_d = PH_FLAG;
				else if (c.is_hchk_disc) phase_d = PH_DEND;
				else phase_d = PH_HUNT;
			end
			default: begin
				phase_d = PH_HUNT;
				if (c.is_flag) begin
					emit   = 1'b1;
					res.ev = EV_DISC;
				end
			end
		endcase

		// A data byte releases the held byte and takes its place.
		if (data_in) begin
			phase_d      = PH_DATA;
			held_d       = data_val;
			held_valid_d = 1'b1;
			if (held_valid_q) begin
				count_d  = count_inc;
				check_d  = check_q ^ held_q;
				emit     = 1'b1;
				res.ev   = EV_DATA;
				res.data = held_q;
				res.cnt  = count_inc;
			end
		end
	end

	// Parser state, advanced once per consumed byte.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q      <= PH_HUNT;
			exp_seq_q    <= 1'b0;
			check_q      <= 8'h00;
			held_q       <= 8'h00;
			held_valid_q <= 1'b0;
			count_q      <= '0;
		end else if (take) begin
			phase_q      <= phase_d;
			exp_seq_q    <= exp_seq_d;
			check_q      <= check_d;
			held_q       <= held_d;
			held_valid_q <= held_valid_d;
			count_q      <= count_d;
		end
	end

	// Result queue storage.
	always_ff @(posedge clk) begin
		if (take && emit) begin
			resq_q[res_wr_q] <= res;
		end
	end

	// Result queue pointers and fill count.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			res_wr_q  <= '0;
			res_rd_q  <= '0;
			res_cnt_q <= '0;
		end else begin
			if (take && emit) res_wr_q <= res_wr_q + 1'b1;
			if (do_pop) res_rd_q <= res_rd_q + 1'b1;
			if ((take && emit) && !do_pop) res_cnt_q <= res_cnt_q + 1'b1;
			else if (!(take && emit) && do_pop) res_cnt_q <= res_cnt_q - 1'b1;
		end
	end

	// The oldest waiting result drives the ports.
	assign event_res     = resq_q[res_rd_q].ev;
	assign data_byte     = resq_q[res_rd_q].data;
	assign ack_seq       = resq_q[res_rd_q].seq;
	assign payload_count = resq_q[res_rd_q].cnt;

endmodule

// ----- sv/info_frame_receiver.sv -----
// Top level of the info frame receiver: byte classifier, queue and frame parser.
//
// Input channel: drive rx_byte and raise push; a transaction completes at a
// rising edge with push high and full low. One line byte per transaction.
// Result channel: while empty is low the oldest result sits on event_res,
// data_byte, ack_seq and payload_count; pop at a rising edge takes it.
// Each byte gives zero or one result: a data byte (held back by one byte so
// the trailing check byte never appears) or one frame event per frame.
// A result passes from the byte queue through the parser into the result
// queue. Throughput: one byte per cycle while the result queue has room,
// set by the parser state machine that consumes one queued byte a cycle.
// A four-entry byte queue and a two-entry result queue separate the sides;
// when pop stays low the result queue fills, the parser stops, and full
// rises once the byte queue holds four bytes.
// Reset clears both queues, the parse state (hunting for a flag) and the
// expected sequence bit.
module info_frame_receiver import ifr_pkg::*; (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             push,
	output logic             full,
	input  logic [7:0]       rx_byte,
	output logic             empty,
	input  logic             pop,
	output logic [2:0]       event_res,
	output logic [7:0]       data_byte,
	output logic             ack_seq,
	output logic [CNT_W-1:0] payload_count
);

	cmd_head_t head;
	logic      take;

	// Front: classify and queue line bytes.
	ifr_front u_front (
		.clk     (clk),
		.arst_n  (arst_n),
		.push    (push),
		.rx_byte (rx_byte),
		.full    (full),
		.head    (head),
		.take    (take)
	);

	// Back: parse frames and queue results.
	ifr_back u_back (
		.clk           (clk),
		.arst_n        (arst_n),
		.head          (head),
		.take          (take),
		.pop           (pop),
		.empty         (empty),
		.event_res     (event_res),
		.data_byte     (data_byte),
		.ack_seq       (ack_seq),
		.payload_count (payload_count)
	);

endmodule
